>>> rtl/core/area_of_interest_event_engine_top_assert.svh
// Assertion macros for the event engine top module.
// Depends on nothing; included by modules that check their own logic.
`ifndef AREA_OF_INTEREST_EVENT_ENGINE_TOP_ASSERT_SVH
`define AREA_OF_INTEREST_EVENT_ENGINE_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define AOI_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AOI_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

>>> rtl/core/aoi_pkg.sv
// Package for the area-of-interest event engine: types, codes and constants.
// Depends on nothing.
package aoi_pkg;
   localparam int SLOTS = 32;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [2:0] KIND_CREATE_ENT = 3'd0;
   localparam logic [2:0] KIND_CREATE_TRG = 3'd1;
   localparam logic [2:0] KIND_MOVE_ENT = 3'd2;
   localparam logic [2:0] KIND_MOVE_TRG = 3'd3;
   localparam logic [2:0] KIND_DELETE_ENT = 3'd4;
   localparam logic [2:0] KIND_DELETE_TRG = 3'd5;

   localparam logic [1:0] EV_ENTER = 2'd0;
   localparam logic [1:0] EV_LEAVE = 2'd1;
   localparam logic [1:0] EV_DONE = 2'd2;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] slot;
      logic [15:0] uid;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_z;
      logic [13:0] half_width;
      logic announce;
   } req_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [15:0] watcher_uid;
      logic [15:0] target_uid;
      logic [1:0] status;
      logic last;
   } rsp_type;

   // One table entry: shared uid, entity point and trigger square.
   typedef struct packed {
      logic [15:0] uid;
      logic signed [15:0] ex;
      logic signed [15:0] ez;
      logic signed [15:0] tx;
      logic signed [15:0] tz;
      logic [13:0] hw;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOK, ST_SWEEP, ST_DRAIN, ST_WRITE, ST_FIN
   } state_type;

   function automatic logic covers(logic signed [15:0] tx, logic signed [15:0] tz,
                                   logic [13:0] hw, logic signed [15:0] ex,
                                   logic signed [15:0] ez);
      logic signed [16:0] dx;
      logic signed [16:0] dz;
      logic [16:0] ax;
      logic [16:0] az;
      dx = 17'(ex) - 17'(tx);
      dz = 17'(ez) - 17'(tz);
      ax = dx[16] ? 17'(-dx) : 17'(dx);
      az = dz[16] ? 17'(-dz) : 17'(dz);
      return (ax <= 17'(hw)) && (az <= 17'(hw));
   endfunction
endpackage

>>> rtl/core/aoi_table.sv
// Slot table memory: one synchronous read port, one write port.
// Depends on aoi_pkg.
module aoi_table (
   input  logic clock,
   input  logic rd_en,
   input  logic [aoi_pkg::SLOT_W-1:0] rd_addr,
   output aoi_pkg::entry_type rd_data,
   input  logic wr_en,
   input  logic [aoi_pkg::SLOT_W-1:0] wr_addr,
   input  aoi_pkg::entry_type wr_data
);
   aoi_pkg::entry_type mem [aoi_pkg::SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> rtl/core/area_of_interest_event_engine_top.sv
// Area-of-interest event engine: one operation at a time over a 32-slot table.
// A rejected operation goes from the look-up to the done beat; a delete without
// events adds the table write; a sweep adds an enter pass and a leave pass over
// all slots, one read a cycle. A new command is taken in the cycle of the done
// beat. Results cannot be stalled. Synchronous reset clears the
// present flags and control state; the table memory itself is not cleared.
module area_of_interest_event_engine_top (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  aoi_pkg::req_type req_data,
   output logic rsp_valid,
   output aoi_pkg::rsp_type rsp_data
);
   `include "area_of_interest_event_engine_top_assert.svh"
   localparam int SW = aoi_pkg::SLOT_W;

   aoi_pkg::state_type state_ff, state_in;
   aoi_pkg::req_type req_ff, req_in;
   aoi_pkg::entry_type self_ff, self_in;
   logic [aoi_pkg::SLOTS-1:0] ent_ff, ent_in, trg_ff, trg_in;
   logic [SW:0] idx_ff, idx_in;
   logic pass_ff, pass_in;
   logic chk_ff, chk_in;
   logic [SW-1:0] chk_idx_ff, chk_idx_in;
   logic [1:0] st_ff, st_in;
   logic rsp_valid_ff, rsp_valid_in;
   aoi_pkg::rsp_type rsp_ff, rsp_in;

   logic rd_en, wr_en;
   logic [SW-1:0] rd_addr, sidx;
   aoi_pkg::entry_type rd_data, wr_data;

   aoi_table u_table (
      .clock(clock), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(sidx), .wr_data(wr_data)
   );

   assign sidx = req_ff.slot[SW-1:0];
   assign busy = (state_ff != aoi_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aoi_pkg::ST_IDLE;
         ent_ff <= '0;
         trg_ff <= '0;
         rsp_valid_ff <= 1'b0;
         chk_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ent_ff <= ent_in;
         trg_ff <= trg_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff <= chk_in;
      end
      req_ff <= req_in;
      self_ff <= self_in;
      idx_ff <= idx_in;
      pass_ff <= pass_in;
      chk_idx_ff <= chk_idx_in;
      st_ff <= st_in;
      rsp_ff <= rsp_in;
   end

   logic is_ent, had_old, has_new, cb, ca, other_present, emit;
   logic signed [15:0] nx, nz;
   logic [13:0] nhw;
   logic [15:0] other_uid;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      self_in = self_ff;
      ent_in = ent_ff;
      trg_in = trg_ff;
      idx_in = idx_ff;
      pass_in = pass_ff;
      chk_in = 1'b0;
      chk_idx_in = idx_ff[SW-1:0];
      st_in = st_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      rd_en = 1'b0;
      rd_addr = sidx;
      wr_en = 1'b0;
      wr_data = self_ff;

      is_ent = (req_ff.kind == aoi_pkg::KIND_CREATE_ENT) ||
               (req_ff.kind == aoi_pkg::KIND_MOVE_ENT) ||
               (req_ff.kind == aoi_pkg::KIND_DELETE_ENT);
      had_old = (req_ff.kind != aoi_pkg::KIND_CREATE_ENT) &&
                (req_ff.kind != aoi_pkg::KIND_CREATE_TRG);
      has_new = (req_ff.kind != aoi_pkg::KIND_DELETE_ENT);
      nx = req_ff.pos_x;
      nz = req_ff.pos_z;
      nhw = (req_ff.kind == aoi_pkg::KIND_CREATE_TRG) ? req_ff.half_width : self_ff.hw;
      other_present = is_ent ? trg_ff[chk_idx_ff] : ent_ff[chk_idx_ff];
      // The slot under change shares its uid with its other half, and a create
      // has not written the new uid to the table yet.
      other_uid = (chk_idx_ff == sidx) ? self_ff.uid : rd_data.uid;
      if (is_ent) begin
         cb = had_old && aoi_pkg::covers(rd_data.tx, rd_data.tz, rd_data.hw,
                                         self_ff.ex, self_ff.ez);
         ca = has_new && aoi_pkg::covers(rd_data.tx, rd_data.tz, rd_data.hw, nx, nz);
      end else begin
         cb = had_old && aoi_pkg::covers(self_ff.tx, self_ff.tz, self_ff.hw,
                                         rd_data.ex, rd_data.ez);
         ca = aoi_pkg::covers(nx, nz, nhw, rd_data.ex, rd_data.ez);
      end
      emit = chk_ff && other_present && (pass_ff ? (cb && !ca) : (ca && !cb));

      // The result of the read launched in the previous cycle is checked here.
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.event_res = pass_ff ? aoi_pkg::EV_LEAVE : aoi_pkg::EV_ENTER;
         rsp_in.watcher_uid = is_ent ? other_uid : self_ff.uid;
         rsp_in.target_uid = is_ent ? self_ff.uid : other_uid;
      end

      case (state_ff)
         aoi_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               state_in = aoi_pkg::ST_LOOK;
               rd_en = 1'b1;
               rd_addr = req_data.slot[SW-1:0];
            end
         end
         aoi_pkg::ST_LOOK: begin
            self_in = rd_data;
            st_in = aoi_pkg::ST_OK;
            idx_in = '0;
            pass_in = 1'b0;
            state_in = aoi_pkg::ST_SWEEP;
            if (req_ff.kind > aoi_pkg::KIND_DELETE_TRG) begin
               state_in = aoi_pkg::ST_FIN;
            end else if (32'(req_ff.slot) >= aoi_pkg::SLOTS) begin
               st_in = aoi_pkg::ST_ABSENT;
               state_in = aoi_pkg::ST_FIN;
            end else begin
               case (req_ff.kind)
                  aoi_pkg::KIND_CREATE_ENT: begin
                     if (ent_ff[sidx]) begin
                        st_in = aoi_pkg::ST_PRESENT;
                        state_in = aoi_pkg::ST_FIN;
                     end else begin
                        self_in.uid = req_ff.uid;
                     end
                  end
                  aoi_pkg::KIND_CREATE_TRG: begin
                     if (trg_ff[sidx]) begin
                        st_in = aoi_pkg::ST_PRESENT;
                        state_in = aoi_pkg::ST_FIN;
                     end else begin
                        self_in.uid = req_ff.uid;
                     end
                  end
                  aoi_pkg::KIND_MOVE_ENT, aoi_pkg::KIND_DELETE_ENT: begin
                     if (!ent_ff[sidx]) begin
                        st_in = aoi_pkg::ST_ABSENT;
                        state_in = aoi_pkg::ST_FIN;
                     end else if (req_ff.kind == aoi_pkg::KIND_DELETE_ENT &&
                                  !req_ff.announce) begin
                        state_in = aoi_pkg::ST_WRITE;
                     end
                  end
                  aoi_pkg::KIND_MOVE_TRG: begin
                     if (!trg_ff[sidx]) begin
                        st_in = aoi_pkg::ST_ABSENT;
                        state_in = aoi_pkg::ST_FIN;
                     end
                  end
                  default: begin
                     if (!trg_ff[sidx]) begin
                        st_in = aoi_pkg::ST_ABSENT;
                        state_in = aoi_pkg::ST_FIN;
                     end else begin
                        state_in = aoi_pkg::ST_WRITE;
                     end
                  end
               endcase
            end
         end
         aoi_pkg::ST_SWEEP: begin
            // The self uid is taken from self_ff, so a create sees its new uid.
            rd_en = 1'b1;
            rd_addr = idx_ff[SW-1:0];
            chk_in = 1'b1;
            chk_idx_in = idx_ff[SW-1:0];
            if (32'(idx_ff) == aoi_pkg::SLOTS - 1) begin
               state_in = aoi_pkg::ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         aoi_pkg::ST_DRAIN: begin
            idx_in = '0;
            if (!pass_ff) begin
               pass_in = 1'b1;
               state_in = aoi_pkg::ST_SWEEP;
            end else begin
               state_in = aoi_pkg::ST_WRITE;
            end
         end
         aoi_pkg::ST_WRITE: begin
            wr_en = 1'b1;
            wr_data = self_ff;
            case (req_ff.kind)
               aoi_pkg::KIND_CREATE_ENT, aoi_pkg::KIND_MOVE_ENT: begin
                  wr_data.ex = nx;
                  wr_data.ez = nz;
                  ent_in[sidx] = 1'b1;
               end
               aoi_pkg::KIND_CREATE_TRG, aoi_pkg::KIND_MOVE_TRG: begin
                  wr_data.tx = nx;
                  wr_data.tz = nz;
                  wr_data.hw = nhw;
                  trg_in[sidx] = 1'b1;
               end
               aoi_pkg::KIND_DELETE_ENT: ent_in[sidx] = 1'b0;
               default: trg_in[sidx] = 1'b0;
            endcase
            state_in = aoi_pkg::ST_FIN;
         end
         aoi_pkg::ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_in.event_res = aoi_pkg::EV_DONE;
            rsp_in.status = st_ff;
            rsp_in.last = 1'b1;
            state_in = aoi_pkg::ST_IDLE;
         end
         default: state_in = aoi_pkg::ST_IDLE;
      endcase
   end

   `AOI_ASSERT_IMP(a_no_start_accept_busy, clock, reset, rsp_valid && rsp_data.last, busy == 1'b0)
   `AOI_ASSERT_NEXT(a_write_then_done, clock, reset, state_ff == aoi_pkg::ST_WRITE, state_ff == aoi_pkg::ST_FIN)
   `AOI_ASSERT_IMP(a_no_event_when_idle, clock, reset, chk_ff, state_ff == aoi_pkg::ST_SWEEP || state_ff == aoi_pkg::ST_DRAIN)
endmodule

>>> test/aoi_event_checker.sv
// Checker for the area-of-interest event engine: watches accepted commands and
// result beats, predicts the event stream from its own slot table and compares.
// Depends on aoi_pkg.
`timescale 1ns / 1ps
module aoi_event_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  aoi_pkg::req_type req_data,
   input  logic rsp_valid,
   input  aoi_pkg::rsp_type rsp_data,
   output int fail_count,
   output int pending_events,
   output int events_seen
);
   logic [15:0] uid_tab [aoi_pkg::SLOTS];
   logic ent_on [aoi_pkg::SLOTS];
   logic signed [15:0] ent_x [aoi_pkg::SLOTS];
   logic signed [15:0] ent_z [aoi_pkg::SLOTS];
   logic trg_on [aoi_pkg::SLOTS];
   logic signed [15:0] trg_x [aoi_pkg::SLOTS];
   logic signed [15:0] trg_z [aoi_pkg::SLOTS];
   logic [13:0] trg_hw [aoi_pkg::SLOTS];

   aoi_pkg::rsp_type expected_beats [$];

   function automatic bit in_square(int tx, int tz, int hw, int ex, int ez);
      int dx;
      int dz;
      dx = ex - tx;
      dz = ez - tz;
      if (dx < 0) dx = -dx;
      if (dz < 0) dz = -dz;
      return (dx <= hw) && (dz <= hw);
   endfunction

   function automatic void push_beat(logic [1:0] res, logic [15:0] w, logic [15:0] t,
                                     logic [1:0] st, logic lst);
      aoi_pkg::rsp_type r;
      r.event_res = res;
      r.watcher_uid = w;
      r.target_uid = t;
      r.status = st;
      r.last = lst;
      expected_beats.push_back(r);
   endfunction

   // Coverage change of entity s against every trigger: enters first, then leaves.
   function automatic void entity_sweep(int s, bit had_old, int ox, int oz, bit has_new,
                                        int nx, int nz);
      bit b;
      bit a;
      for (int pass = 0; pass < 2; pass++)
         for (int t = 0; t < aoi_pkg::SLOTS; t++) begin
            if (!trg_on[t]) continue;
            b = had_old && in_square(trg_x[t], trg_z[t], trg_hw[t], ox, oz);
            a = has_new && in_square(trg_x[t], trg_z[t], trg_hw[t], nx, nz);
            if (pass == 0 && a && !b)
               push_beat(aoi_pkg::EV_ENTER, uid_tab[t], uid_tab[s], aoi_pkg::ST_OK, 0);
            if (pass == 1 && b && !a)
               push_beat(aoi_pkg::EV_LEAVE, uid_tab[t], uid_tab[s], aoi_pkg::ST_OK, 0);
         end
   endfunction

   function automatic void trigger_sweep(int s, bit had_old, int ox, int oz, int ohw,
                                         int nx, int nz, int nhw);
      bit b;
      bit a;
      for (int pass = 0; pass < 2; pass++)
         for (int e = 0; e < aoi_pkg::SLOTS; e++) begin
            if (!ent_on[e]) continue;
            b = had_old && in_square(ox, oz, ohw, ent_x[e], ent_z[e]);
            a = in_square(nx, nz, nhw, ent_x[e], ent_z[e]);
            if (pass == 0 && a && !b)
               push_beat(aoi_pkg::EV_ENTER, uid_tab[s], uid_tab[e], aoi_pkg::ST_OK, 0);
            if (pass == 1 && b && !a)
               push_beat(aoi_pkg::EV_LEAVE, uid_tab[s], uid_tab[e], aoi_pkg::ST_OK, 0);
         end
   endfunction

   function automatic void predict_command(aoi_pkg::req_type c);
      int s;
      logic [1:0] st;
      s = c.slot;
      st = aoi_pkg::ST_OK;
      case (c.kind)
         aoi_pkg::KIND_CREATE_ENT: begin
            if (ent_on[s]) st = aoi_pkg::ST_PRESENT;
            else begin
               uid_tab[s] = c.uid;
               entity_sweep(s, 0, 0, 0, 1, c.pos_x, c.pos_z);
               ent_on[s] = 1;
               ent_x[s] = c.pos_x;
               ent_z[s] = c.pos_z;
            end
         end
         aoi_pkg::KIND_CREATE_TRG: begin
            if (trg_on[s]) st = aoi_pkg::ST_PRESENT;
            else begin
               uid_tab[s] = c.uid;
               trigger_sweep(s, 0, 0, 0, 0, c.pos_x, c.pos_z, c.half_width);
               trg_on[s] = 1;
               trg_x[s] = c.pos_x;
               trg_z[s] = c.pos_z;
               trg_hw[s] = c.half_width;
            end
         end
         aoi_pkg::KIND_MOVE_ENT: begin
            if (!ent_on[s]) st = aoi_pkg::ST_ABSENT;
            else begin
               entity_sweep(s, 1, ent_x[s], ent_z[s], 1, c.pos_x, c.pos_z);
               ent_x[s] = c.pos_x;
               ent_z[s] = c.pos_z;
            end
         end
         aoi_pkg::KIND_MOVE_TRG: begin
            if (!trg_on[s]) st = aoi_pkg::ST_ABSENT;
            else begin
               trigger_sweep(s, 1, trg_x[s], trg_z[s], trg_hw[s], c.pos_x, c.pos_z,
                             trg_hw[s]);
               trg_x[s] = c.pos_x;
               trg_z[s] = c.pos_z;
            end
         end
         aoi_pkg::KIND_DELETE_ENT: begin
            if (!ent_on[s]) st = aoi_pkg::ST_ABSENT;
            else begin
               if (c.announce) entity_sweep(s, 1, ent_x[s], ent_z[s], 0, 0, 0);
               ent_on[s] = 0;
            end
         end
         aoi_pkg::KIND_DELETE_TRG: begin
            if (!trg_on[s]) st = aoi_pkg::ST_ABSENT;
            else trg_on[s] = 0;
         end
         default: st = aoi_pkg::ST_OK;
      endcase
      push_beat(aoi_pkg::EV_DONE, 16'd0, 16'd0, st, 1);
   endfunction

   always @(posedge clock) begin
      aoi_pkg::rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < aoi_pkg::SLOTS; i++) begin
            ent_on[i] = 0;
            trg_on[i] = 0;
         end
         expected_beats.delete();
         fail_count <= 0;
         events_seen <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with nothing expected: %p", rsp_data);
               errs++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data.event_res != aoi_pkg::EV_DONE) events_seen <= events_seen + 1;
               if (rsp_data.event_res !== want.event_res) begin
                  $error("event_res expected %0d got %0d", want.event_res, rsp_data.event_res);
                  errs++;
               end
               if (rsp_data.watcher_uid !== want.watcher_uid) begin
                  $error("watcher_uid expected %h got %h", want.watcher_uid,
                         rsp_data.watcher_uid);
                  errs++;
               end
               if (rsp_data.target_uid !== want.target_uid) begin
                  $error("target_uid expected %h got %h", want.target_uid,
                         rsp_data.target_uid);
                  errs++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_data.status);
                  errs++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, rsp_data.last);
                  errs++;
               end
            end
         end
         // The command is predicted after the response check so that a beat in
         // this same cycle is matched against the older queue contents.
         if (start && !busy) predict_command(req_data);
         fail_count <= fail_count + errs;
      end
      pending_events <= expected_beats.size();
   end
endmodule

>>> test/tb_top.sv
// Testbench top for the area-of-interest event engine: clock, reset, command
// stimulus and verdict. Depends on aoi_pkg, the engine and aoi_event_checker.
`timescale 1ns / 1ps
module tb_top;
   localparam int WATCHDOG_CYCLES = 5000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   aoi_pkg::req_type req_data = '0;
   logic rsp_valid;
   aoi_pkg::rsp_type rsp_data;
   int fail_count;
   int pending_events;
   int events_seen;
   int idle_cycles = 0;
   int commands_sent = 0;
   logic [15:0] next_uid = 16'h0100;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   area_of_interest_event_engine_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   aoi_event_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending_events(pending_events), .events_seen(events_seen)
   );

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Holds one command on the port until the engine takes it. Start stays high
   // afterwards so that the next command of a burst can follow directly.
   task automatic issue(aoi_pkg::req_type c);
      req_data <= c;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      commands_sent++;
   endtask

   // Drops start for a gap between bursts; nothing is done when n is zero.
   task automatic pause(int n);
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic aoi_pkg::req_type make_cmd(logic [2:0] k, int s, int x, int z,
                                                 int hw, bit ann);
      aoi_pkg::req_type c;
      c.kind = k;
      c.slot = 5'(s);
      c.uid = next_uid;
      next_uid = next_uid + 16'd1;
      c.pos_x = 16'(x);
      c.pos_z = 16'(z);
      c.half_width = 14'(hw);
      c.announce = ann;
      return c;
   endfunction

   // Clustered coordinates so that squares overlap often; a few are far out.
   function automatic int coord();
      if ($urandom_range(9) == 0) return $signed(16'($urandom));
      return $signed(16'($urandom_range(32'd200))) - 100;
   endfunction

   function automatic aoi_pkg::req_type random_cmd();
      aoi_pkg::req_type c;
      logic [95:0] raw;
      int r;
      r = $urandom_range(99);
      if (r < 2) begin
         raw = {$urandom, $urandom, $urandom};
         c = raw[$bits(aoi_pkg::req_type)-1:0];
         c.kind = 3'($urandom_range(7));
         return c;
      end
      c = make_cmd(3'($urandom_range(5)), $urandom_range(31), coord(), coord(),
                   ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(80),
                   $urandom_range(1));
      c.uid = 16'($urandom);
      return c;
   endfunction

   initial begin
      aoi_pkg::req_type c;
      int gap;
      int burst;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, border ties, duplicates, absent targets, odd kinds.
      issue(make_cmd(aoi_pkg::KIND_MOVE_ENT, 3, 0, 0, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_DELETE_TRG, 3, 0, 0, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_DELETE_ENT, 3, 0, 0, 0, 1));
      issue(make_cmd(aoi_pkg::KIND_MOVE_TRG, 31, 0, 0, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_CREATE_TRG, 0, 0, 0, 10, 0));
      issue(make_cmd(aoi_pkg::KIND_CREATE_ENT, 1, 10, -10, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_CREATE_ENT, 2, 11, 0, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_CREATE_ENT, 1, 0, 0, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_CREATE_TRG, 0, 0, 0, 5, 0));
      issue(make_cmd(aoi_pkg::KIND_CREATE_TRG, 31, 32767, 32767, 16383, 0));
      issue(make_cmd(aoi_pkg::KIND_CREATE_ENT, 31, -32768, -32768, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_CREATE_TRG, 30, -32768, 32767, 16383, 0));
      issue(make_cmd(aoi_pkg::KIND_MOVE_ENT, 2, 10, 10, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_MOVE_TRG, 0, 30, 30, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_MOVE_TRG, 0, 0, 0, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_CREATE_TRG, 1, 5, 5, 16383, 0));
      issue(make_cmd(aoi_pkg::KIND_DELETE_ENT, 2, 0, 0, 0, 1));
      issue(make_cmd(aoi_pkg::KIND_DELETE_ENT, 1, 0, 0, 0, 0));
      issue(make_cmd(aoi_pkg::KIND_DELETE_TRG, 0, 0, 0, 0, 0));
      issue(make_cmd(3'd6, 4, 0, 0, 0, 1));
      issue(make_cmd(3'd7, 5, 0, 0, 0, 0));
      c = aoi_pkg::req_type'('1);
      issue(c);

      // Random bursts with random gaps between them.
      while (commands_sent < 268) begin
         burst = $urandom_range(12, 1);
         repeat (burst) issue(random_cmd());
         gap = $urandom_range(3) == 0 ? 0 : $urandom_range(40);
         pause(gap);
      end
      start <= 0;

      while (pending_events != 0 || busy) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("sent %0d commands; %0d enter/leave beats compared",
               commands_sent, events_seen);
      if (fail_count == 0 && pending_events == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
